[sv/ipdt_pkg.sv]
// Shared types and constants for the pulse-distance IR frame transmitter.
package ipdt_pkg;

    // Widths fixed by the configuration and word formats.
    localparam int DUR_W      = 16;
    localparam int BITS_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PAYLOAD_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARK  = 3'd0,
        CFG_START_SPACE = 3'd1,
        CFG_BIT_MARK    = 3'd2,
        CFG_ONE_SPACE   = 3'd3,
        CFG_ZERO_SPACE  = 3'd4,
        CFG_END_MARK    = 3'd5,
        CFG_FRAME_BITS  = 3'd6
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [DUR_W-1:0]  RST_START_MARK  = 16'd16;
    localparam logic [DUR_W-1:0]  RST_START_SPACE = 16'd8;
    localparam logic [DUR_W-1:0]  RST_BIT_MARK    = 16'd1;
    localparam logic [DUR_W-1:0]  RST_ONE_SPACE   = 16'd3;
    localparam logic [DUR_W-1:0]  RST_ZERO_SPACE  = 16'd1;
    localparam logic [DUR_W-1:0]  RST_END_MARK    = 16'd1;
    localparam logic [BITS_W-1:0] RST_FRAME_BITS  = 6'd8;

    // Word request codes.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // Current configuration as seen by the frame sequencer.
    typedef struct packed {
        logic [DUR_W-1:0]  start_mark;
        logic [DUR_W-1:0]  start_space;
        logic [DUR_W-1:0]  bit_mark;
        logic [DUR_W-1:0]  one_space;
        logic [DUR_W-1:0]  zero_space;
        logic [DUR_W-1:0]  end_mark;
        logic [BITS_W-1:0] frame_bits;
    } cfg_t;

    // One input word held in the input stage.
    typedef struct packed {
        logic                 req_type;
        logic [PAYLOAD_W-1:0] payload;
    } item_t;

    // Line phases of a frame.
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START_MARK  = 3'd1,
        PH_START_SPACE = 3'd2,
        PH_BIT_MARK    = 3'd3,
        PH_BIT_SPACE   = 3'd4,
        PH_END_MARK    = 3'd5
    } phase_t;

endpackage

[sv/ipdt_cfg_regs.sv]
// Configuration register file of the IR frame transmitter.
module ipdt_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ipdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipdt_pkg::CFG_DATA_W-1:0] cfg_data,
    output ipdt_pkg::cfg_t                 cfg
);
    import ipdt_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_mark  <= RST_START_MARK;
            cfg_reg.start_space <= RST_START_SPACE;
            cfg_reg.bit_mark    <= RST_BIT_MARK;
            cfg_reg.one_space   <= RST_ONE_SPACE;
            cfg_reg.zero_space  <= RST_ZERO_SPACE;
            cfg_reg.end_mark    <= RST_END_MARK;
            cfg_reg.frame_bits  <= RST_FRAME_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_MARK:  cfg_reg.start_mark  <= cfg_data[DUR_W-1:0];
                CFG_START_SPACE: cfg_reg.start_space <= cfg_data[DUR_W-1:0];
                CFG_BIT_MARK:    cfg_reg.bit_mark    <= cfg_data[DUR_W-1:0];
                CFG_ONE_SPACE:   cfg_reg.one_space   <= cfg_data[DUR_W-1:0];
                CFG_ZERO_SPACE:  cfg_reg.zero_space  <= cfg_data[DUR_W-1:0];
                CFG_END_MARK:    cfg_reg.end_mark    <= cfg_data[DUR_W-1:0];
                CFG_FRAME_BITS:  cfg_reg.frame_bits  <= cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ipdt_in_stage.sv]
// Input register stage that captures one word ahead of the frame sequencer.
module ipdt_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [ipdt_pkg::PAYLOAD_W-1:0] s_payload,
    output logic                          item_valid,
    output ipdt_pkg::item_t               item,
    input  logic                          item_take
);
    import ipdt_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The stage refills in the same cycle in which its word moves on.
    assign s_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type <= s_req_type;
            item_reg.payload  <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/ipdt_frame_fsm.sv]
// Frame sequencer: phase state, tick counter, data shifter and result register.
module ipdt_frame_fsm #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ipdt_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  ipdt_pkg::item_t item,
    output logic            item_take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_line_level,
    output logic            m_busy_res,
    output logic            m_frame_done,
    output logic            m_request_dropped
);
    import ipdt_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [BITS_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [DATA_WIDTH-1:0]  shift_reg, shift_next;

    logic m_valid_reg;
    logic level_reg, busy_reg, done_reg, dropped_reg;

    logic              start_frame;
    logic              last_tick;
    logic [BITS_W-1:0] bits_sat;
    logic [BITS_W-1:0] bit_idx_inc;
    logic              level_d, done_d, dropped_d;

    // A word moves on whenever the result register is free or being emptied.
    assign item_take = item_valid && (!m_valid_reg || m_ready);

    // Frame request while idle starts a frame and uses no tick.
    assign start_frame = (item.req_type == REQ_FRAME) && (phase_reg == PH_IDLE);
    assign last_tick   = !(tick_reg > COUNT_WIDTH'(1));
    assign bits_sat    = (cfg.frame_bits > BITS_W'(DATA_WIDTH)) ? BITS_W'(DATA_WIDTH)
                                                                 : cfg.frame_bits;
    assign bit_idx_inc = bit_idx_reg + BITS_W'(1);

    // Next state of the sequencer for the word now in the input stage.
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        if (start_frame) begin
            phase_next   = PH_START_MARK;
            tick_next    = COUNT_WIDTH'(cfg.start_mark);
            bit_idx_next = '0;
            shift_next   = item.payload[DATA_WIDTH-1:0];
        end else if (phase_reg != PH_IDLE) begin
            if (!last_tick) begin
                tick_next = tick_reg - COUNT_WIDTH'(1);
            end else begin
                unique case (phase_reg)
                    PH_START_MARK: begin
                        phase_next = PH_START_SPACE;
                        tick_next  = COUNT_WIDTH'(cfg.start_space);
                    end
                    PH_START_SPACE: begin
                        if (bits_sat == '0) begin
                            phase_next = PH_END_MARK;
                            tick_next  = COUNT_WIDTH'(cfg.end_mark);
                        end else begin
                            phase_next = PH_BIT_MARK;
                            tick_next  = COUNT_WIDTH'(cfg.bit_mark);
                        end
                    end
                    PH_BIT_MARK: begin
                        phase_next = PH_BIT_SPACE;
                        tick_next  = shift_reg[0] ? COUNT_WIDTH'(cfg.one_space)
                                                  : COUNT_WIDTH'(cfg.zero_space);
                    end
                    PH_BIT_SPACE: begin
                        shift_next   = shift_reg >> 1;
                        bit_idx_next = bit_idx_inc;
                        if (bit_idx_inc < bits_sat) begin
                            phase_next = PH_BIT_MARK;
                            tick_next  = COUNT_WIDTH'(cfg.bit_mark);
                        end else begin
                            phase_next = PH_END_MARK;
                            tick_next  = COUNT_WIDTH'(cfg.end_mark);
                        end
                    end
                    PH_END_MARK: begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                endcase
            end
        end
    end

    // Result fields for the word now in the input stage.
    always_comb begin
        level_d   = 1'b0;
        done_d    = 1'b0;
        dropped_d = (item.req_type == REQ_FRAME) && (phase_reg != PH_IDLE);
        if (!start_frame && phase_reg != PH_IDLE) begin
            level_d = (phase_reg == PH_START_MARK) || (phase_reg == PH_BIT_MARK) ||
                      (phase_reg == PH_END_MARK);
            done_d  = (phase_reg == PH_END_MARK) && last_tick;
        end
    end

    // Sequencer state advances once per word taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
        end else if (item_take) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= item_valid;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (item_take) begin
            level_reg   <= level_d;
            busy_reg    <= (phase_next != PH_IDLE);
            done_reg    <= done_d;
            dropped_reg <= dropped_d;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_line_level      = level_reg;
    assign m_busy_res        = busy_reg;
    assign m_frame_done      = done_reg;
    assign m_request_dropped = dropped_reg;

endmodule

[sv/ir_pulse_distance_frame_tx_top.sv]
// Top level of the pulse-distance IR frame transmitter.
//
//   Port group  Direction  Handshake         Word contents
//   s_*         in         s_valid/s_ready   s_req_type, s_payload
//   m_*         out        m_valid/m_ready   m_line_level, m_busy_res, m_frame_done,
//                                            m_request_dropped
//   cfg_*       in         cfg_wr_en         cfg_index, cfg_data
//
// An accepted input word is loaded first into the input register and then into the
// result register. One word is taken every cycle while m_ready does not stall the
// result register, and the phase and counter update once per word taken.
// A synchronous active-low reset on aresetn clears the stage valid flags and the
// sequencer and loads the configuration reset values. A stall on m_ready holds the
// result and fills the input register, after which s_ready drops.
module ir_pulse_distance_frame_tx_top #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [ipdt_pkg::PAYLOAD_W-1:0]   s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_line_level,
    output logic                            m_busy_res,
    output logic                            m_frame_done,
    output logic                            m_request_dropped,
    input  logic                            cfg_wr_en,
    input  logic [ipdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ipdt_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    // Configuration registers.
    ipdt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register stage.
    ipdt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_payload  (s_payload),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Frame sequencer and result register.
    ipdt_frame_fsm #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .item_valid        (item_valid),
        .item              (item),
        .item_take         (item_take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_line_level      (m_line_level),
        .m_busy_res        (m_busy_res),
        .m_frame_done      (m_frame_done),
        .m_request_dropped (m_request_dropped)
    );

endmodule
